// ----- design/e2q_pkg.sv -----
// e2q_pkg: shared constants, types and tables for the euler to quaternion unit
// no dependencies
package e2q_pkg;

  localparam int TrigIterations = 16;
  localparam int AtanEntries = 24;
  localparam int CordicSteps = (TrigIterations < AtanEntries) ? TrigIterations : AtanEntries;

  localparam int AngleW = 16;
  localparam int XyW = 33;   // cordic x/y, 30 fraction bits, magnitude below 1.7
  localparam int ZW = 25;    // angle accumulator, 2^-16 degree
  localparam int TrigW = 22; // cos/sin, 20 fraction bits
  localparam int QuatW = 16;

  localparam logic signed [XyW-1:0] CordicGain = 33'sd652032874;
  localparam logic signed [16:0] HalfTurn = 17'sd23040;
  localparam logic signed [16:0] FullTurn = 17'sd46080;
  localparam logic signed [16:0] QuarterTurn = 17'sd11520;
  localparam logic signed [QuatW-1:0] Q14One = 16'sd16384;

  typedef logic signed [XyW-1:0] xy_t;
  typedef logic signed [ZW-1:0] z_t;
  typedef logic signed [TrigW-1:0] trig_t;

  // one cordic lane: rotation vector, residual angle, fold sign
  typedef struct packed {
    xy_t x;
    xy_t y;
    z_t z;
    logic neg;
  } lane_t;

  typedef struct packed {
    lane_t yaw;
    lane_t pitch;
    lane_t roll;
  } cell_data_t;

  function automatic z_t atan_entry(input int i);
    case (i)
      0: atan_entry = 25'sd2949120;
      1: atan_entry = 25'sd1740967;
      2: atan_entry = 25'sd919879;
      3: atan_entry = 25'sd466945;
      4: atan_entry = 25'sd234379;
      5: atan_entry = 25'sd117304;
      6: atan_entry = 25'sd58666;
      7: atan_entry = 25'sd29335;
      8: atan_entry = 25'sd14668;
      9: atan_entry = 25'sd7334;
      10: atan_entry = 25'sd3667;
      11: atan_entry = 25'sd1833;
      12: atan_entry = 25'sd917;
      13: atan_entry = 25'sd458;
      14: atan_entry = 25'sd229;
      15: atan_entry = 25'sd115;
      16: atan_entry = 25'sd57;
      17: atan_entry = 25'sd29;
      18: atan_entry = 25'sd14;
      19: atan_entry = 25'sd7;
      20: atan_entry = 25'sd4;
      21: atan_entry = 25'sd2;
      22: atan_entry = 25'sd1;
      default: atan_entry = 25'sd0;
    endcase
  endfunction

  // wrap and fold raw angle (half angle in 1/128 deg), seed a lane
  function automatic lane_t fold_angle(input logic signed [AngleW-1:0] raw);
    logic signed [16:0] a;
    lane_t l;
    a = 17'(raw);
    l.neg = 1'b0;
    if (a >= HalfTurn) a = a - FullTurn;
    else if (a < -HalfTurn) a = a + FullTurn;
    if (a > QuarterTurn) begin
      a = a - HalfTurn;
      l.neg = 1'b1;
    end else if (a < -QuarterTurn) begin
      a = a + HalfTurn;
      l.neg = 1'b1;
    end
    l.x = CordicGain;
    l.y = '0;
    l.z = {a[15:0], 9'd0};
    return l;
  endfunction

  function automatic lane_t rotate(input lane_t l, input int i);
    xy_t dx;
    xy_t dy;
    lane_t r;
    dx = l.y >>> i;
    dy = l.x >>> i;
    r = l;
    if (!l.z[ZW-1]) begin
      r.x = l.x - dx;
      r.y = l.y + dy;
      r.z = l.z - atan_entry(i);
    end else begin
      r.x = l.x + dx;
      r.y = l.y - dy;
      r.z = l.z + atan_entry(i);
    end
    return r;
  endfunction

endpackage

// ----- design/e2q_cell.sv -----
// e2q_cell: one cordic micro-rotation for all three angle lanes, registered
// depends on e2q_pkg
module e2q_cell (
  input  logic clk,
  input  logic rst,
  input  logic enable,
  input  logic [4:0] step,
  input  logic valid_in,
  input  e2q_pkg::cell_data_t data_in,
  output logic valid_out,
  output e2q_pkg::cell_data_t data_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (enable) begin
      valid_out <= valid_in;
    end
    if (enable) begin
      data_out.yaw <= e2q_pkg::rotate(data_in.yaw, int'(step));
      data_out.pitch <= e2q_pkg::rotate(data_in.pitch, int'(step));
      data_out.roll <= e2q_pkg::rotate(data_in.roll, int'(step));
    end
  end

endmodule

// ----- design/e2q_combine.sv -----
// e2q_combine: rounds cos/sin, forms pair and triple products, rounds to q1.14
// depends on e2q_pkg
module e2q_combine (
  input  logic clk,
  input  logic rst,
  input  logic enable,
  input  logic valid_in,
  input  e2q_pkg::cell_data_t data_in,
  output logic valid_out,
  output logic signed [15:0] quat_w,
  output logic signed [15:0] quat_x,
  output logic signed [15:0] quat_y,
  output logic signed [15:0] quat_z
);

  localparam int TW = e2q_pkg::TrigW;

  logic [2:0] vld;
  e2q_pkg::trig_t cy, sy, cp, sp, cr, sr;
  e2q_pkg::trig_t cc, ss, sc, cs, cr2, sr2;
  logic signed [2*TW-1:0] t_cc_cr, t_ss_sr, t_cc_sr, t_ss_cr;
  logic signed [2*TW-1:0] t_sc_sr, t_cs_cr, t_sc_cr, t_cs_sr;

  function automatic e2q_pkg::trig_t round_trig(input e2q_pkg::xy_t v, input logic neg);
    e2q_pkg::xy_t r;
    r = (v + e2q_pkg::xy_t'(512)) >>> 10;
    if (neg) r = -r;
    return r[TW-1:0];
  endfunction

  function automatic e2q_pkg::trig_t pair(input e2q_pkg::trig_t a, input e2q_pkg::trig_t b);
    logic signed [2*TW-1:0] p;
    p = (a * b + (2*TW)'(1 << 19)) >>> 20;
    return p[TW-1:0];
  endfunction

  function automatic logic signed [15:0] to_q14(input logic signed [2*TW-1:0] a,
                                                input logic signed [2*TW-1:0] b,
                                                input logic sub);
    logic signed [2*TW:0] s;
    logic signed [2*TW:0] v;
    s = sub ? ((2*TW+1)'(a) - (2*TW+1)'(b)) : ((2*TW+1)'(a) + (2*TW+1)'(b));
    v = (s + (2*TW+1)'(1 << 25)) >>> 26;
    if (v > (2*TW+1)'(e2q_pkg::Q14One)) return e2q_pkg::Q14One;
    if (v < -(2*TW+1)'(e2q_pkg::Q14One)) return -e2q_pkg::Q14One;
    return v[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (enable) begin
      vld <= {vld[1:0], valid_in};
    end
    if (enable) begin
      // stage a: round
      cy <= round_trig(data_in.yaw.x, data_in.yaw.neg);
      sy <= round_trig(data_in.yaw.y, data_in.yaw.neg);
      cp <= round_trig(data_in.pitch.x, data_in.pitch.neg);
      sp <= round_trig(data_in.pitch.y, data_in.pitch.neg);
      cr <= round_trig(data_in.roll.x, data_in.roll.neg);
      sr <= round_trig(data_in.roll.y, data_in.roll.neg);
      // stage b: pair products
      cc <= pair(cy, cp);
      ss <= pair(sy, sp);
      sc <= pair(sy, cp);
      cs <= pair(cy, sp);
      cr2 <= cr;
      sr2 <= sr;
      // stage c: triple products
      t_cc_cr <= cc * cr2;
      t_ss_sr <= ss * sr2;
      t_cc_sr <= cc * sr2;
      t_ss_cr <= ss * cr2;
      t_sc_sr <= sc * sr2;
      t_cs_cr <= cs * cr2;
      t_sc_cr <= sc * cr2;
      t_cs_sr <= cs * sr2;
      // stage d: sums and rounding
      quat_w <= to_q14(t_cc_cr, t_ss_sr, 1'b0);
      quat_x <= to_q14(t_cc_sr, t_ss_cr, 1'b1);
      quat_y <= to_q14(t_sc_sr, t_cs_cr, 1'b0);
      quat_z <= to_q14(t_sc_cr, t_cs_sr, 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (enable) begin
      valid_out <= vld[2];
    end
  end

endmodule

// ----- design/euler_to_quaternion_unit.sv -----
// euler_to_quaternion_unit: top level, zyx euler angles to q1.14 quaternion
// depends on e2q_pkg, e2q_cell, e2q_combine
//
// channel | handshake        | payload
// input   | valid / ready    | yaw_angle, pitch_angle, roll_angle (1/64 deg)
// output  | out_valid / out_ready | quat_w, quat_x, quat_y, quat_z (q1.14)
//
// one item per cycle is accepted while the output is not stalled; the path is
// the fold register, one cordic cell per micro-rotation and four combine stages,
// the last of which is the output register. the whole pipeline advances
// when the output register is empty or being taken, so a stall on the
// output holds every stage.
// reset clears only the valid bits.
module euler_to_quaternion_unit (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic ready,
  input  logic signed [15:0] yaw_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] roll_angle,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [15:0] quat_w,
  output logic signed [15:0] quat_x,
  output logic signed [15:0] quat_y,
  output logic signed [15:0] quat_z
);

  localparam int N = e2q_pkg::CordicSteps;

  logic enable;
  logic fold_valid;
  e2q_pkg::cell_data_t fold_data;
  logic [N:0] chain_valid;
  e2q_pkg::cell_data_t chain_data [N+1];

  // pipeline moves whenever the output slot is free or drained this cycle
  assign enable = !out_valid || out_ready;
  assign ready = enable;

  // angle fold into +-90 degrees of half angle
  always_ff @(posedge clk) begin
    if (rst) begin
      fold_valid <= 1'b0;
    end else if (enable) begin
      fold_valid <= valid;
    end
    if (enable) begin
      fold_data.yaw <= e2q_pkg::fold_angle(yaw_angle);
      fold_data.pitch <= e2q_pkg::fold_angle(pitch_angle);
      fold_data.roll <= e2q_pkg::fold_angle(roll_angle);
    end
  end

  assign chain_valid[0] = fold_valid;
  assign chain_data[0] = fold_data;

  // row of cordic cells, one micro-rotation each; each cell is told its step
  for (genvar i = 0; i < N; i++) begin : g_cell
    e2q_cell u_cell (
      .clk(clk),
      .rst(rst),
      .enable(enable),
      .step(5'(i)),
      .valid_in(chain_valid[i]),
      .data_in(chain_data[i]),
      .valid_out(chain_valid[i+1]),
      .data_out(chain_data[i+1])
    );
  end

  e2q_combine u_combine (
    .clk(clk),
    .rst(rst),
    .enable(enable),
    .valid_in(chain_valid[N]),
    .data_in(chain_data[N]),
    .valid_out(out_valid),
    .quat_w(quat_w),
    .quat_x(quat_x),
    .quat_y(quat_y),
    .quat_z(quat_z)
  );

endmodule
